// ===== hw/rtl/idq_pkg.sv =====
package idq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OP_W       = 3;
   localparam int POSITION_W = 4;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int FOUND_W    = 4;
   localparam int COUNT_W    = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_TAKE = 3'd2,
      OP_GET  = 3'd3,
      OP_SET  = 3'd4,
      OP_FIND = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_EMPTY     = 3'd1,
      STS_FULL      = 3'd2,
      STS_BAD_POS   = 3'd3,
      STS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCAN
   } state_type;

   typedef enum logic [2:0] {
      OFS_COUNT,
      OFS_LAST,
      OFS_ZERO,
      OFS_POS,
      OFS_NEXT
   } offset_sel_type;

   typedef struct packed {
      logic           load;
      logic           mem_wr;
      logic           mem_rd;
      offset_sel_type offset_sel;
      logic           count_inc;
      logic           count_dec;
      logic           head_inc;
      logic           scan_clear;
      logic           scan_inc;
      logic           respond;
      status_type     rsp_status;
      logic           rsp_use_data;
      logic           rsp_use_scan;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   pos_bad;
      logic   match;
      logic   scan_last;
   } flags_type;

endpackage

// ===== hw/rtl/idq_ctrl.sv =====
module idq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  idq_pkg::flags_type flags,
   output idq_pkg::cmd_type   cmd
);
   import idq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (flags.op)
               OP_PUSH: begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
                  if (flags.full) begin
                     cmd.rsp_status = STS_FULL;
                  end else begin
                     cmd.mem_wr     = 1'b1;
                     cmd.offset_sel = OFS_COUNT;
                     cmd.count_inc  = 1'b1;
                     cmd.rsp_status = STS_OK;
                  end
               end
               OP_POP: begin
                  if (flags.empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STS_EMPTY;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.mem_rd     = 1'b1;
                     cmd.offset_sel = OFS_LAST;
                     cmd.count_dec  = 1'b1;
                     state_in       = ST_READ;
                  end
               end
               OP_TAKE: begin
                  if (flags.empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STS_EMPTY;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.mem_rd     = 1'b1;
                     cmd.offset_sel = OFS_ZERO;
                     cmd.count_dec  = 1'b1;
                     cmd.head_inc   = 1'b1;
                     state_in       = ST_READ;
                  end
               end
               OP_GET: begin
                  if (flags.pos_bad) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STS_BAD_POS;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.mem_rd     = 1'b1;
                     cmd.offset_sel = OFS_POS;
                     state_in       = ST_READ;
                  end
               end
               OP_SET: begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
                  if (flags.pos_bad) begin
                     cmd.rsp_status = STS_BAD_POS;
                  end else begin
                     cmd.mem_wr     = 1'b1;
                     cmd.offset_sel = OFS_POS;
                     cmd.rsp_status = STS_OK;
                  end
               end
               OP_FIND: begin
                  if (flags.empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STS_NOT_FOUND;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.mem_rd     = 1'b1;
                     cmd.offset_sel = OFS_ZERO;
                     cmd.scan_clear = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = STS_OK;
                  state_in       = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            cmd.respond      = 1'b1;
            cmd.rsp_status   = STS_OK;
            cmd.rsp_use_data = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_SCAN: begin
            if (flags.match) begin
               cmd.respond      = 1'b1;
               cmd.rsp_status   = STS_OK;
               cmd.rsp_use_scan = 1'b1;
               state_in         = ST_IDLE;
            end else if (flags.scan_last) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = STS_NOT_FOUND;
               state_in       = ST_IDLE;
            end else begin
               cmd.mem_rd     = 1'b1;
               cmd.offset_sel = OFS_NEXT;
               cmd.scan_inc   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/idq_datapath.sv =====
module idq_datapath #(
   parameter int DEPTH      = idq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = idq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [idq_pkg::OP_W-1:0]        req_op,
   input  logic [idq_pkg::POSITION_W-1:0]  req_position,
   input  logic [idq_pkg::VALUE_W-1:0]     req_value,
   input  idq_pkg::cmd_type                cmd,
   output idq_pkg::flags_type              flags,
   output logic                            rsp_valid,
   output logic [idq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [idq_pkg::VALUE_W-1:0]     rsp_read_value,
   output logic [idq_pkg::FOUND_W-1:0]     rsp_found_index,
   output logic [idq_pkg::COUNT_W-1:0]     rsp_entry_count
);
   import idq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] entries_ff [DEPTH];

   op_type                  op_ff;
   logic [POSITION_W-1:0]   position_ff;
   logic [DATA_WIDTH-1:0]   value_ff;
   logic [IDX_W-1:0]        head_ff;
   logic [IDX_W-1:0]        head_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [IDX_W-1:0]        scan_idx_ff;
   logic [IDX_W-1:0]        scan_idx_in;
   logic [DATA_WIDTH-1:0]   rd_data_ff;

   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [VALUE_W-1:0]      rsp_read_value_ff;
   logic [FOUND_W-1:0]      rsp_found_index_ff;
   logic [COUNT_W-1:0]      rsp_entry_count_ff;

   logic [IDX_W-1:0]        offset;
   logic [IDX_W:0]          ring_sum;
   logic [IDX_W-1:0]        addr;

   always_comb begin
      case (cmd.offset_sel)
         OFS_COUNT: offset = IDX_W'(count_ff);
         OFS_LAST:  offset = IDX_W'(count_ff - CNT_W'(1));
         OFS_ZERO:  offset = '0;
         OFS_POS:   offset = IDX_W'(position_ff);
         OFS_NEXT:  offset = scan_idx_ff + IDX_W'(1);
         default:   offset = '0;
      endcase
   end

   assign ring_sum = {1'b0, head_ff} + {1'b0, offset};
   assign addr = (ring_sum >= (IDX_W + 1)'(DEPTH)) ?
                 IDX_W'(ring_sum - (IDX_W + 1)'(DEPTH)) : IDX_W'(ring_sum);

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      head_in = head_ff;
      if (cmd.head_inc) begin
         head_in = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.scan_clear) begin
         scan_idx_in = '0;
      end else if (cmd.scan_inc) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= op_type'(req_op);
         position_ff <= req_position;
         value_ff    <= DATA_WIDTH'(req_value);
      end
      scan_idx_ff <= scan_idx_in;
      if (cmd.respond) begin
         rsp_status_ff      <= cmd.rsp_status;
         rsp_read_value_ff  <= cmd.rsp_use_data ? VALUE_W'(rd_data_ff) : '0;
         rsp_found_index_ff <= cmd.rsp_use_scan ? FOUND_W'(scan_idx_ff) : '0;
         rsp_entry_count_ff <= COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         entries_ff[addr] <= value_ff;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= entries_ff[addr];
      end
   end

   assign flags.op        = op_ff;
   assign flags.empty     = (count_ff == '0);
   assign flags.full      = (count_ff == CNT_W'(DEPTH));
   assign flags.pos_bad   = (32'(position_ff) >= 32'(count_ff));
   assign flags.match     = (rd_data_ff == value_ff);
   assign flags.scan_last = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_found_index = rsp_found_index_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

// ===== hw/rtl/indexed_double_ended_queue_core.sv =====
// Bounded double-ended queue of data words held in a ring of DEPTH entries.
// A request transfer happens at a rising edge where start is high and busy is
// low; req_op selects push tail, pop tail, take head, get, set or find.
// Every request produces exactly one response, shown on the rsp_ ports for
// one cycle while rsp_valid is high, with the entry count after the request.
// Push, set, rejected requests and unused op codes respond from the execute
// state, and the next request can be taken while their response is shown.
// Pop, take and get read the entry store through its registered port in the
// execute state and respond from the read state. Find compares one entry per
// cycle starting at the head, and responds on a match or after the last entry.
// Busy stays high from the request transfer until the response is issued.
// The receiver cannot stall, so every response is taken in its one cycle.
// Reset empties the queue and clears the head index; stored words are not
// cleared, and only words written since reset are ever returned.
module indexed_double_ended_queue_core #(
   parameter int DEPTH      = idq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = idq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [idq_pkg::OP_W-1:0]        req_op,
   input  logic [idq_pkg::POSITION_W-1:0]  req_position,
   input  logic [idq_pkg::VALUE_W-1:0]     req_value,
   output logic                            rsp_valid,
   output logic [idq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [idq_pkg::VALUE_W-1:0]     rsp_read_value,
   output logic [idq_pkg::FOUND_W-1:0]     rsp_found_index,
   output logic [idq_pkg::COUNT_W-1:0]     rsp_entry_count
);
   import idq_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   idq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .flags (flags),
      .cmd   (cmd)
   );

   idq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_value       (req_value),
      .cmd             (cmd),
      .flags           (flags),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ===== sim/tb.sv =====
module tb;
   import idq_pkg::*;

   localparam int DEPTH           = DEPTH_DEFAULT;
   localparam int ITEMS_PER_PHASE = 325;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int SETTLE_CYCLES   = DEPTH + 8;
   localparam int MAX_REPORTS     = 10;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      status_type           status;
      logic [VALUE_W-1:0]   read_value;
      logic [FOUND_W-1:0]   found_index;
      logic [COUNT_W-1:0]   entry_count;
   } deque_result_type;

   class deque_scoreboard;
      logic [VALUE_W-1:0]    words [DEPTH];
      logic [POSITION_W-1:0] head;
      logic [COUNT_W-1:0]    count;
      deque_result_type      pending_results[$];
      int                    mismatches;

      function new();
         head       = '0;
         count      = '0;
         mismatches = 0;
      endfunction

      function logic [POSITION_W-1:0] ring(logic [POSITION_W-1:0] pos);
         ring = head + pos;
      endfunction

      function logic [VALUE_W-1:0] live_word(logic [POSITION_W-1:0] pos);
         live_word = words[ring(pos)];
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [POSITION_W-1:0] pos,
                                 logic [VALUE_W-1:0] val);
         deque_result_type r;
         int               i;
         r.status      = STS_OK;
         r.read_value  = '0;
         r.found_index = '0;
         case (op)
            OP_PUSH: begin
               if (count == DEPTH) begin
                  r.status = STS_FULL;
               end else begin
                  words[ring(count[POSITION_W-1:0])] = val;
                  count++;
               end
            end
            OP_POP: begin
               if (count == 0) begin
                  r.status = STS_EMPTY;
               end else begin
                  count--;
                  r.read_value = words[ring(count[POSITION_W-1:0])];
               end
            end
            OP_TAKE: begin
               if (count == 0) begin
                  r.status = STS_EMPTY;
               end else begin
                  r.read_value = words[head];
                  head++;
                  count--;
               end
            end
            OP_GET: begin
               if ({1'b0, pos} >= count) begin
                  r.status = STS_BAD_POS;
               end else begin
                  r.read_value = words[ring(pos)];
               end
            end
            OP_SET: begin
               if ({1'b0, pos} >= count) begin
                  r.status = STS_BAD_POS;
               end else begin
                  words[ring(pos)] = val;
               end
            end
            OP_FIND: begin
               r.status = STS_NOT_FOUND;
               for (i = 0; i < count; i++) begin
                  if (words[ring(i[POSITION_W-1:0])] == val) begin
                     r.status      = STS_OK;
                     r.found_index = i[FOUND_W-1:0];
                     break;
                  end
               end
            end
            default: ;
         endcase
         r.entry_count = count;
         pending_results.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] rd,
                                   logic [FOUND_W-1:0] fidx, logic [COUNT_W-1:0] cnt);
         deque_result_type e;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("Unexpected response: status %0d value %h index %0d count %0d",
                        status, rd, fidx, cnt);
            return;
         end
         e = pending_results.pop_front();
         if (status !== e.status || rd !== e.read_value || fidx !== e.found_index ||
             cnt !== e.entry_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $write("Mismatch: expected status %0d value %h index %0d count %0d, ",
                      e.status, e.read_value, e.found_index, e.entry_count);
               $display("got status %0d value %h index %0d count %0d",
                        status, rd, fidx, cnt);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OP_W-1:0]        req_op = '0;
   logic [POSITION_W-1:0]  req_position = '0;
   logic [VALUE_W-1:0]     req_value = '0;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [VALUE_W-1:0]     rsp_read_value;
   logic [FOUND_W-1:0]     rsp_found_index;
   logic [COUNT_W-1:0]     rsp_entry_count;

   deque_scoreboard sb = new();
   int              idle_pct = 0;
   int              cycle_count = 0;
   bit              filling = 1'b1;

   indexed_double_ended_queue_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("indexed_double_ended_queue_core verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_status, rsp_read_value, rsp_found_index, rsp_entry_count);
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [POSITION_W-1:0] pos,
                               input logic [VALUE_W-1:0] val);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_op       <= op;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (busy);
      sb.note_request(op, pos, val);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [OP_W-1:0] pick_op();
      int r;
      r = $urandom_range(99);
      if (sb.count == DEPTH) filling = 1'b0;
      if (sb.count == 0) filling = 1'b1;
      if ($urandom_range(99) < 2) filling = ~filling;
      if (r < 5) return ($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
      if (filling) begin
         if (r < 50) return OP_PUSH;
         if (r < 58) return OP_POP;
         if (r < 66) return OP_TAKE;
      end else begin
         if (r < 13) return OP_PUSH;
         if (r < 39) return OP_POP;
         if (r < 66) return OP_TAKE;
      end
      if (r < 78) return OP_GET;
      if (r < 88) return OP_SET;
      return OP_FIND;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(logic [OP_W-1:0] op);
      int r;
      r = $urandom_range(9);
      if (op == OP_FIND && sb.count != 0 && $urandom_range(1) != 0)
         return sb.live_word(POSITION_W'($urandom_range(0, sb.count - 1)));
      if (r < 5) return $urandom;
      if (r < 7) return $urandom_range(0, 3);
      if (r < 8) return '0;
      if (r < 9) return '1;
      return {8'($urandom_range(0, 255)), 24'h0};
   endfunction

   initial begin
      logic [OP_W-1:0]       op;
      logic [POSITION_W-1:0] pos;
      int                    phase;
      int                    k;
      int                    phase_idle [4];

      phase_idle = '{0, 63, 0, 19};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Requests against an empty queue, then the unused op codes.
      send_request(OP_POP, 4'd0, 32'h0);
      send_request(OP_TAKE, 4'd0, 32'h0);
      send_request(OP_GET, 4'd0, 32'h0);
      send_request(OP_SET, 4'd15, 32'hFFFF_FFFF);
      send_request(OP_FIND, 4'd0, 32'h0);
      send_request(OP_SPARE_LO, 4'd15, 32'hFFFF_FFFF);
      send_request(OP_SPARE_HI, 4'd7, 32'h5A5A_5A5A);
      // Fill the queue with extreme and repeated words, then overflow it.
      for (k = 0; k < DEPTH; k++)
         send_request(OP_PUSH, 4'd0, (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF :
                      (k % 5 == 0) ? 32'h1 : k * 32'h0101_0101);
      send_request(OP_PUSH, 4'd0, 32'hDEAD_BEEF);
      send_request(OP_GET, 4'd15, 32'h0);
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         idle_pct = phase_idle[phase];
         repeat (ITEMS_PER_PHASE) begin
            op = pick_op();
            if (sb.count != 0 && $urandom_range(99) < 70)
               pos = POSITION_W'($urandom_range(0, sb.count - 1));
            else
               pos = POSITION_W'($urandom_range(0, 15));
            send_request(op, pos, pick_value(op));
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("indexed_double_ended_queue_core verification clean");
      end else begin
         $display("indexed_double_ended_queue_core verification failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/idq_pkg.sv
hw/rtl/idq_ctrl.sv
hw/rtl/idq_datapath.sv
hw/rtl/indexed_double_ended_queue_core.sv
sim/tb.sv
